// File: sv/bsd_pkg.sv
// Shared types and constants of the button/switch debouncer.
`default_nettype none
package bsd_pkg;

	typedef enum logic [1:0] {
		PH_IDLE         = 2'd0,
		PH_PRESS_LOCK   = 2'd1,
		PH_HELD         = 2'd2,
		PH_RELEASE_LOCK = 2'd3
	} phase_t;

	localparam logic [1:0] DEV_BUTTON = 2'd0;
	localparam logic [1:0] DEV_HOLD   = 2'd1;
	localparam logic [1:0] DEV_SWITCH = 2'd2;

	localparam logic CFG_DEVICE_TYPE   = 1'b0;
	localparam logic CFG_DEBOUNCE_TICKS = 1'b1;

	localparam int unsigned TICK_W = 16;
	localparam logic [TICK_W-1:0] TICK_MAX = '1;
	localparam logic [1:0] DEVICE_TYPE_RST = DEV_BUTTON;
	localparam logic [TICK_W-1:0] DEBOUNCE_TICKS_RST = 16'd100;

	typedef struct packed {
		logic [1:0]        device_type;
		logic [TICK_W-1:0] debounce_ticks;
	} cfg_t;

	typedef struct packed {
		logic pin_level;
		logic read_error;
		logic tick;
	} sample_t;

	typedef struct packed {
		logic   status;
		logic   ok;
		phase_t phase_out;
	} result_t;

endpackage
`default_nettype wire

// File: sv/bsd_core.sv
// Debounce state registers and per-word phase update logic.
`default_nettype none
module bsd_core (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             step,
	input  wire bsd_pkg::sample_t sample,
	input  wire bsd_pkg::cfg_t    cfg,
	output bsd_pkg::result_t      result
);

	bsd_pkg::phase_t                   phase_q, phase_d;
	logic                              status_q, status_d;
	logic [bsd_pkg::TICK_W-1:0]        elapsed_q, elapsed_d, elapsed_inc;
	logic                              ok;
	logic                              is_btn;

	always_comb begin
		is_btn = (cfg.device_type == bsd_pkg::DEV_BUTTON) ||
			(cfg.device_type == bsd_pkg::DEV_HOLD);
		elapsed_inc = (sample.tick && (elapsed_q != bsd_pkg::TICK_MAX)) ?
			elapsed_q + 1'b1 : elapsed_q;
		phase_d   = phase_q;
		status_d  = status_q;
		elapsed_d = elapsed_q;
		ok        = 1'b1;
		case (phase_q)
			bsd_pkg::PH_IDLE: begin
				if (sample.read_error) begin
					ok = 1'b0;
				end else if (!sample.pin_level) begin
					if (is_btn) begin
						elapsed_d = '0;
						phase_d   = bsd_pkg::PH_PRESS_LOCK;
						status_d  = (cfg.device_type == bsd_pkg::DEV_BUTTON) ?
							1'b1 : ~status_q;
					end else if (cfg.device_type == bsd_pkg::DEV_SWITCH) begin
						status_d = 1'b1;
						phase_d  = bsd_pkg::PH_HELD;
					end
				end
			end
			bsd_pkg::PH_HELD: begin
				if (sample.read_error) begin
					ok = 1'b0;
				end else if (sample.pin_level) begin
					if (is_btn) begin
						elapsed_d = '0;
						phase_d   = bsd_pkg::PH_RELEASE_LOCK;
						if (cfg.device_type == bsd_pkg::DEV_BUTTON) begin
							status_d = 1'b0;
						end
					end else if (cfg.device_type == bsd_pkg::DEV_SWITCH) begin
						status_d = 1'b0;
						phase_d  = bsd_pkg::PH_IDLE;
					end
				end
			end
			default: begin
				elapsed_d = elapsed_inc;
				if (elapsed_inc > cfg.debounce_ticks) begin
					phase_d = (phase_q == bsd_pkg::PH_PRESS_LOCK) ?
						bsd_pkg::PH_HELD : bsd_pkg::PH_IDLE;
				end
			end
		endcase
		result.status    = status_d;
		result.ok        = ok;
		result.phase_out = phase_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= bsd_pkg::PH_IDLE;
			status_q  <= 1'b0;
			elapsed_q <= '0;
		end else if (step) begin
			phase_q   <= phase_d;
			status_q  <= status_d;
			elapsed_q <= elapsed_d;
		end
	end

endmodule
`default_nettype wire

// File: sv/button_switch_debounce_fsm_core.sv
// Top level of the button/switch debouncer: input stage, state core, output register.
//
// Qualifies one active-low pin, one sample word at a time, as a momentary button,
// a toggling hold-button or a level switch, with a lockout after each button press or
// release until its count of timer ticks passes debounce_ticks. One word is taken every
// clock unless the input stalls; each word gives exactly one result word. The rate is
// set by the phase/status/elapsed registers in bsd_core, which update once per word
// from shallow compare and increment logic. The input stage keeps accepting while a
// result waits on m_tready, until both the input and output registers are full.
`default_nettype none
module button_switch_debounce_fsm_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // pin_level, read_error, tick, zero fill
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [7:0]       m_tdata,   // status, ok, phase_out[1:0], zero fill
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [15:0] cfg_data
);

	bsd_pkg::cfg_t    cfg_q;
	bsd_pkg::sample_t sample_s1;
	logic             valid_s1;
	bsd_pkg::result_t result;
	bsd_pkg::result_t result_s2;
	logic             valid_s2;
	logic             advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.device_type    <= bsd_pkg::DEVICE_TYPE_RST;
			cfg_q.debounce_ticks <= bsd_pkg::DEBOUNCE_TICKS_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				bsd_pkg::CFG_DEVICE_TYPE:    cfg_q.device_type    <= cfg_data[1:0];
				bsd_pkg::CFG_DEBOUNCE_TICKS: cfg_q.debounce_ticks <= cfg_data;
				default: ;
			endcase
		end
	end

	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			sample_s1.pin_level  <= s_tdata[0];
			sample_s1.read_error <= s_tdata[1];
			sample_s1.tick       <= s_tdata[2];
		end
	end

	bsd_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.sample (sample_s1),
		.cfg    (cfg_q),
		.result (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= result;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {4'b0000, result_s2.phase_out, result_s2.ok, result_s2.status};

	a_no_needless_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (valid_s1 && valid_s2 && !m_tready))
		else $error("input stalled with room in the pipeline");

	a_step_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> m_tvalid)
		else $error("processed word produced no result");

	a_err_only_when_reading: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tdata[1]) |->
			(m_tdata[3:2] == bsd_pkg::PH_IDLE || m_tdata[3:2] == bsd_pkg::PH_HELD))
		else $error("read error reported during a lockout");

endmodule
`default_nettype wire
